// File: sv/trie_prefix_word_matcher_defines.svh
// Assertion macros used by the checker file of the trie matcher.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TRIE_PREFIX_WORD_MATCHER_DEFINES_SVH
`define TRIE_PREFIX_WORD_MATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trie matcher check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trie matcher check failed");

`endif

// File: sv/tpwm_pkg.sv
package tpwm_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_LOAD_NODE = 2'd0;
  localparam logic [1:0] CMD_LOAD_EDGE = 2'd1;
  localparam logic [1:0] CMD_LETTER    = 2'd2;
  localparam logic [1:0] CMD_CLEAR     = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ON_PATH = 2'd1;
  localparam logic [1:0] ST_FOUND   = 2'd2;
  localparam logic [1:0] ST_DEAD    = 2'd3;

  // Width of the prefix length port and counter.
  localparam int LEN_W = 6;

  // One entry of the node memory.
  typedef struct packed {
    logic [15:0] start;
    logic        is_word;
  } node_entry_t;

  // One entry of the edge memory.
  typedef struct packed {
    logic [7:0]  label;
    logic [15:0] child;
  } edge_entry_t;

endpackage

// File: sv/trie_prefix_word_matcher.sv
// Channel  Direction  Handshake          Payload
// input    in         in_valid/in_stall  command index first_edge word_end edge_label
//                                        edge_target letter word_start
// output   out        out_valid/out_stall status prefix_length node_reached
//
// A load item writes its entry and passes straight to the result state. A letter
// reads its node, scans the current node's edge list edge by edge and then reads
// the target node back for its word mark; a dead walk goes to the result at once.
// A clear item sweeps the reported marks, one node per cycle, over all NODES nodes.
// After reset the same sweep runs over all NODES nodes before the first item is taken.
// An item is taken only when the sequencer is idle; a stalled result holds in the
// output register while the next item is already accepted.
module trie_prefix_word_matcher #(
  parameter int NODES    = 65536,
  parameter int EDGES    = 65536,
  parameter int MAX_WORD = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 command,
  input  logic [15:0]                index,
  input  logic [15:0]                first_edge,
  input  logic                       word_end,
  input  logic [7:0]                 edge_label,
  input  logic [15:0]                edge_target,
  input  logic [7:0]                 letter,
  input  logic                       word_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [tpwm_pkg::LEN_W-1:0] prefix_length,
  output logic [15:0]                node_reached
);
  import tpwm_pkg::*;

  localparam int NAW = $clog2(NODES);
  localparam int EAW = $clog2(EDGES);
  localparam int ECW = ((EAW > 16) ? EAW : 16) + 1;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_NODE   = 3'd2;
  localparam logic [2:0] S_EDGE   = 3'd3;
  localparam logic [2:0] S_WORD   = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  // Memories and their registered read data.
  node_entry_t node_mem [NODES];
  edge_entry_t edge_mem [EDGES];
  logic        rep_mem  [NODES];
  node_entry_t node_q;
  edge_entry_t edge_q;
  logic        reported_q;

  // Sequencer and walk registers.
  logic [2:0]       state, state_next;
  logic [15:0]      cur_node, cur_node_next;
  logic             walk_dead, walk_dead_next;
  logic [LEN_W-1:0] letters_seen, letters_seen_next;
  logic [ECW-1:0]   edge_ptr, edge_ptr_next;
  logic [NAW-1:0]   sweep, sweep_next;
  logic [7:0]       letter_q, letter_q_next;
  logic [1:0]       res_status, res_status_next;
  logic [LEN_W-1:0] res_len, res_len_next;
  logic [15:0]      res_node, res_node_next;
  logic             out_valid_next;
  logic             out_load;

  // Memory controls.
  logic           node_rd_en;
  logic [NAW-1:0] node_rd_addr;
  logic           node_we;
  logic           edge_rd_en;
  logic [EAW-1:0] edge_rd_addr;
  logic           edge_we;
  logic           rep_we;
  logic [NAW-1:0] rep_waddr;
  logic           rep_wdata;

  // Helpers for the letter path.
  logic             accept;
  logic [15:0]      eff_cur;
  logic             eff_dead;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] len_inc;
  logic [ECW-1:0]   ptr_inc;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign eff_cur  = word_start ? 16'd0 : cur_node;
  assign eff_dead = word_start ? 1'b0 : walk_dead;
  assign eff_len  = word_start ? '0 : letters_seen;
  assign len_inc  = (letters_seen < LEN_W'(MAX_WORD)) ? letters_seen + LEN_W'(1) : letters_seen;
  assign ptr_inc  = edge_ptr + ECW'(1);
  assign out_load = (state == S_RESULT) && (!out_valid || !out_stall);

  // Sequencer: next state, walk updates and memory controls.
  always_comb begin
    state_next        = state;
    cur_node_next     = cur_node;
    walk_dead_next    = walk_dead;
    letters_seen_next = letters_seen;
    edge_ptr_next     = edge_ptr;
    sweep_next        = sweep;
    letter_q_next     = letter_q;
    res_status_next   = res_status;
    res_len_next      = res_len;
    res_node_next     = res_node;
    node_rd_en        = 1'b0;
    node_rd_addr      = NAW'(cur_node);
    node_we           = 1'b0;
    edge_rd_en        = 1'b0;
    edge_rd_addr      = EAW'(edge_ptr);
    edge_we           = 1'b0;
    rep_we            = 1'b0;
    rep_waddr         = sweep;
    rep_wdata         = 1'b0;

    case (state)
      S_INIT, S_CLEAR: begin
        // Sweep every reported mark back to zero, one node a cycle.
        rep_we     = 1'b1;
        rep_waddr  = sweep;
        sweep_next = sweep + NAW'(1);
        if (sweep == NAW'(NODES - 1)) begin
          state_next = (state == S_INIT) ? S_IDLE : S_RESULT;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_DONE;
          res_len_next    = '0;
          res_node_next   = 16'd0;
          state_next      = S_RESULT;
          case (command)
            CMD_LOAD_NODE: begin
              if (32'(index) < NODES) begin
                node_we   = 1'b1;
                rep_we    = 1'b1;
                rep_waddr = NAW'(index);
                rep_wdata = 1'b0;
              end
            end
            CMD_LOAD_EDGE: begin
              edge_we = (32'(index) < EDGES);
            end
            CMD_CLEAR: begin
              sweep_next = '0;
              state_next = S_CLEAR;
            end
            CMD_LETTER: begin
              // A new word restarts the walk at the root before the letter is used.
              cur_node_next     = eff_cur;
              walk_dead_next    = eff_dead;
              letters_seen_next = eff_len;
              letter_q_next     = letter;
              if (eff_dead || (32'(eff_cur) >= NODES)) begin
                walk_dead_next  = 1'b1;
                res_status_next = ST_DEAD;
                res_len_next    = eff_len;
              end else begin
                node_rd_en   = 1'b1;
                node_rd_addr = NAW'(eff_cur);
                state_next   = S_NODE;
              end
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_NODE: begin
        // Start the scan at the node's first edge.
        if (32'(node_q.start) < EDGES) begin
          edge_rd_en    = 1'b1;
          edge_rd_addr  = EAW'(node_q.start);
          edge_ptr_next = ECW'(node_q.start);
          state_next    = S_EDGE;
        end else begin
          walk_dead_next  = 1'b1;
          res_status_next = ST_DEAD;
          res_len_next    = letters_seen;
          res_node_next   = 16'd0;
          state_next      = S_RESULT;
        end
      end
      S_EDGE: begin
        if (edge_q.label == 8'd0 ||
            (edge_q.label == letter_q && edge_q.child == 16'd0)) begin
          // End of list, or an edge back to the root: the walk dies.
          walk_dead_next  = 1'b1;
          res_status_next = ST_DEAD;
          res_len_next    = letters_seen;
          res_node_next   = 16'd0;
          state_next      = S_RESULT;
        end else if (edge_q.label == letter_q) begin
          cur_node_next     = edge_q.child;
          letters_seen_next = len_inc;
          res_status_next   = ST_ON_PATH;
          res_len_next      = len_inc;
          res_node_next     = edge_q.child;
          if (32'(edge_q.child) < NODES) begin
            node_rd_en   = 1'b1;
            node_rd_addr = NAW'(edge_q.child);
            state_next   = S_WORD;
          end else begin
            state_next = S_RESULT;
          end
        end else if (32'(ptr_inc) < EDGES) begin
          // Fetch the following edge of the list.
          edge_rd_en    = 1'b1;
          edge_rd_addr  = EAW'(ptr_inc);
          edge_ptr_next = ptr_inc;
        end else begin
          walk_dead_next  = 1'b1;
          res_status_next = ST_DEAD;
          res_len_next    = letters_seen;
          res_node_next   = 16'd0;
          state_next      = S_RESULT;
        end
      end
      S_WORD: begin
        // Report a word node the first time it is reached.
        if (node_q.is_word && !reported_q) begin
          rep_we          = 1'b1;
          rep_waddr       = NAW'(cur_node);
          rep_wdata       = 1'b1;
          res_status_next = ST_FOUND;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register: holds while stalled.
  assign out_valid_next = out_load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      cur_node     <= 16'd0;
      walk_dead    <= 1'b0;
      letters_seen <= '0;
      sweep        <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      cur_node     <= cur_node_next;
      walk_dead    <= walk_dead_next;
      letters_seen <= letters_seen_next;
      sweep        <= sweep_next;
      out_valid    <= out_valid_next;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    edge_ptr   <= edge_ptr_next;
    letter_q   <= letter_q_next;
    res_status <= res_status_next;
    res_len    <= res_len_next;
    res_node   <= res_node_next;
    if (out_load) begin
      status        <= res_status;
      prefix_length <= res_len;
      node_reached  <= res_node;
    end
  end

  // Node memory with registered read.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[NAW'(index)] <= '{start: first_edge, is_word: word_end};
    end
    if (node_rd_en) begin
      node_q <= node_mem[node_rd_addr];
    end
  end

  // Reported marks, read alongside the node memory.
  always_ff @(posedge clk) begin
    if (rep_we) begin
      rep_mem[rep_waddr] <= rep_wdata;
    end
    if (node_rd_en) begin
      reported_q <= rep_mem[node_rd_addr];
    end
  end

  // Edge memory with registered read.
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[EAW'(index)] <= '{label: edge_label, child: edge_target};
    end
    if (edge_rd_en) begin
      edge_q <= edge_mem[edge_rd_addr];
    end
  end

endmodule

// File: sv/tpwm_checker.sv
`include "trie_prefix_word_matcher_defines.svh"

module tpwm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [1:0]                 command,
  input logic [15:0]                index,
  input logic [15:0]                first_edge,
  input logic                       word_end,
  input logic [7:0]                 edge_label,
  input logic [15:0]                edge_target,
  input logic [7:0]                 letter,
  input logic                       word_start,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 status,
  input logic [tpwm_pkg::LEN_W-1:0] prefix_length,
  input logic [15:0]                node_reached
);
  import tpwm_pkg::*;

  // A stalled result stays valid and unchanged.
  `TPWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(prefix_length) && $stable(node_reached))

  // The block works on one item at a time, so it is busy right after taking one.
  `TPWM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // A live walk always names the node it reached, and a new word has a length.
  `TPWM_ASSERT_NOW(a_live_node, out_valid && (status == ST_ON_PATH || status == ST_FOUND), node_reached != 16'd0 && prefix_length != '0)

  // Dead walks and load or clear results name no node; the latter carry no length.
  `TPWM_ASSERT_NOW(a_idle_fields, out_valid && (status == ST_DEAD || status == ST_DONE), node_reached == 16'd0 && (status == ST_DEAD || prefix_length == '0))

endmodule

bind trie_prefix_word_matcher tpwm_checker u_tpwm_checker (.*);
